// File: sv/mmbp_pkg.sv
// ----------------------------------------------------------------------------
// mmbp_pkg
// shared types, constants and helpers of the multi-mode branch predictor
// ----------------------------------------------------------------------------
package mmbp_pkg;

  localparam int GLOBAL_BITS_DEF = 13;
  localparam int LOCAL_BITS_DEF  = 10;
  localparam int PC_BITS_DEF     = 10;
  localparam int SECOND_BITS_DEF = 13;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GBITS  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LBITS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PBITS  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SBITS  = 3'd4;

  localparam logic [1:0] CTR_WEAK_NT = 2'd1;
  localparam logic [1:0] CTR_MAX     = 2'd3;

  typedef enum logic [1:0] {
    MODE_STATIC     = 2'd0,
    MODE_GSHARE     = 2'd1,
    MODE_TOURNAMENT = 2'd2,
    MODE_CUSTOM     = 2'd3
  } mode_t;

  typedef enum logic {
    FUNC_PREDICT = 1'b0,
    FUNC_TRAIN   = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_EVAL
  } state_t;

  function automatic logic [15:0] width_mask(input logic [CFG_DATA_W-1:0] r, input int mx);
    int b;
    b = (r == '0) ? 1 : int'(r);
    if (b > mx) b = mx;
    return 16'((17'd1 << b) - 17'd1);
  endfunction

  function automatic logic [1:0] bump(input logic [1:0] c, input logic taken);
    logic [1:0] r;
    r = c;
    if (taken) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != 2'd0) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

// File: sv/mmbp_ram.sv
// ----------------------------------------------------------------------------
// mmbp_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module mmbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: sv/multi_mode_branch_predictor_unit.sv
// ----------------------------------------------------------------------------
// multi_mode_branch_predictor_unit
// static, gshare, tournament and confidence-selected branch predictor
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | func, pc, outcome
//  out     | output    | out_valid / out_stall | prediction
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  one item at a time, in steps: latch, table read, local counter read, update
//  the local counter read depends on the local history read, which sets the chain
//  after reset a clearing pass over 2**max(table index bits) addresses (8192 by
//  default) holds in_stall high; configuration writes are taken throughout
//  a waiting prediction beat does not block the next accept
// ----------------------------------------------------------------------------
module multi_mode_branch_predictor_unit #(
  parameter int GLOBAL_BITS_MAX = mmbp_pkg::GLOBAL_BITS_DEF,
  parameter int LOCAL_BITS_MAX  = mmbp_pkg::LOCAL_BITS_DEF,
  parameter int PC_BITS_MAX     = mmbp_pkg::PC_BITS_DEF,
  parameter int SECOND_BITS_MAX = mmbp_pkg::SECOND_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             func,
  input  logic [31:0]                      pc,
  input  logic                             outcome,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             prediction,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mmbp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mmbp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mmbp_pkg::*;

  localparam int GB = GLOBAL_BITS_MAX;
  localparam int LB = LOCAL_BITS_MAX;
  localparam int PB = PC_BITS_MAX;
  localparam int SB = SECOND_BITS_MAX;
  localparam int M1 = (GB > SB) ? GB : SB;
  localparam int M2 = (LB > PB) ? LB : PB;
  localparam int CW = (M1 > M2) ? M1 : M2;

  state_t state, state_next;

  logic [1:0]            mode;
  logic [CFG_DATA_W-1:0] gbits, lbits, pbits, sbits;
  logic [GB-1:0]         ghist;
  logic [SB-1:0]         shist;
  logic [CW-1:0]         clr_cnt;
  logic                  item_func;
  logic [31:0]           item_pc;
  logic                  item_outcome;

  logic [GB-1:0] gm, gh, gsi, g_raddr, g_waddr, g_waddr_ev;
  logic [LB-1:0] lm, lh, lc_waddr;
  logic [PB-1:0] pm, pi, p_waddr;
  logic [SB-1:0] sm, sh, si, s_waddr;

  logic [1:0]    g_rd, s_rd, ch_rd, lc_rd;
  logic [LB-1:0] lhist_rd;
  logic [5:0]    cf_rd;

  logic g_we, s_we, ch_we, lc_we, lh_we, cf_we;
  logic [1:0]    g_wd, s_wd, ch_wd, lc_wd;
  logic [LB-1:0] lh_wd;
  logic [5:0]    cf_wd;

  logic g_we_ev, s_we_ev, ch_we_ev, lc_we_ev, lh_we_ev, cf_we_ev;
  logic [1:0]    g_wd_ev, ch_wd_ev, cf_new [3];
  logic [1:0]    cf [3];
  logic          comp [3];
  logic          any_sure, g_pred, s_pred, l_pred, pred, train, tk;
  logic          ev_done, out_load, hist_upd, shist_upd;

  assign gm = GB'(width_mask(gbits, GB));
  assign lm = LB'(width_mask(lbits, LB));
  assign pm = PB'(width_mask(pbits, PB));
  assign sm = SB'(width_mask(sbits, SB));

  assign gh  = ghist & gm;
  assign sh  = shist & sm;
  assign pi  = item_pc[PB-1:0] & pm;
  assign lh  = lhist_rd & lm;
  assign gsi = (item_pc[GB-1:0] & gm) ^ gh;
  assign si  = (item_pc[SB-1:0] ^ sh) & sm;
  assign g_raddr = (mode == MODE_GSHARE) ? gsi : gh;

  assign train  = (item_func == FUNC_TRAIN);
  assign tk     = item_outcome;
  assign g_pred = g_rd[1];
  assign s_pred = s_rd[1];
  assign l_pred = lc_rd[1];

  for (genvar k = 0; k < 3; k++) begin : g_cf
    assign cf[k] = cf_rd[2*k+1:2*k];
  end
  assign comp[0] = g_pred;
  assign comp[1] = s_pred;
  assign comp[2] = l_pred;

  always_comb begin
    any_sure = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (comp[k] == tk && cf[k] == CTR_MAX) any_sure = 1'b1;
    end
    for (int k = 0; k < 3; k++) begin
      cf_new[k] = cf[k];
      if (any_sure) begin
        if (comp[k] != tk && cf[k] != 2'd0) cf_new[k] = cf[k] - 2'd1;
      end else begin
        if (comp[k] == tk && cf[k] != CTR_MAX) cf_new[k] = cf[k] + 2'd1;
      end
    end
  end

  always_comb begin
    pred = 1'b1;
    ch_wd_ev = ch_rd;
    case (mode)
      MODE_STATIC:     pred = 1'b1;
      MODE_GSHARE:     pred = g_pred;
      MODE_TOURNAMENT: begin
        pred = (ch_rd <= CTR_WEAK_NT) ? g_pred : l_pred;
        if (l_pred == tk && g_pred != tk) ch_wd_ev = bump(ch_rd, 1'b1);
        else if (l_pred != tk && g_pred == tk) ch_wd_ev = bump(ch_rd, 1'b0);
      end
      MODE_CUSTOM: begin
        if (cf[0] == CTR_MAX) pred = g_pred;
        else if (cf[1] == CTR_MAX) pred = s_pred;
        else if (cf[2] == CTR_MAX) pred = l_pred;
        else pred = g_pred;
      end
      default: pred = 1'b1;
    endcase
  end

  assign g_wd_ev = bump(g_rd, tk);
  assign g_waddr_ev = g_raddr;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == '1) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid && !in_stall) state_next = ST_RD1;
      ST_RD1:   state_next = ST_RD2;
      ST_RD2:   state_next = ST_EVAL;
      ST_EVAL:  if (ev_done) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs and write strobes
  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_load  = 1'b0;
    ev_done   = 1'b0;
    g_we_ev   = 1'b0;
    s_we_ev   = 1'b0;
    ch_we_ev  = 1'b0;
    lc_we_ev  = 1'b0;
    lh_we_ev  = 1'b0;
    cf_we_ev  = 1'b0;
    hist_upd  = 1'b0;
    shist_upd = 1'b0;
    case (state)
      ST_EVAL: begin
        if (train) begin
          ev_done = 1'b1;
          case (mode)
            MODE_GSHARE: begin
              g_we_ev  = 1'b1;
              hist_upd = 1'b1;
            end
            MODE_TOURNAMENT: begin
              g_we_ev  = 1'b1;
              lc_we_ev = 1'b1;
              ch_we_ev = 1'b1;
              lh_we_ev = 1'b1;
              hist_upd = 1'b1;
            end
            MODE_CUSTOM: begin
              g_we_ev   = 1'b1;
              lc_we_ev  = 1'b1;
              s_we_ev   = 1'b1;
              cf_we_ev  = 1'b1;
              lh_we_ev  = 1'b1;
              hist_upd  = 1'b1;
              shist_upd = 1'b1;
            end
            default: ev_done = 1'b1;
          endcase
        end else if (!out_valid || !out_stall) begin
          ev_done  = 1'b1;
          out_load = 1'b1;
        end
      end
      default: ev_done = 1'b0;
    endcase
  end

  assign cfg_ready = 1'b1;

  wire clearing = (state == ST_CLEAR);
  assign g_we  = clearing | g_we_ev;
  assign s_we  = clearing | s_we_ev;
  assign ch_we = clearing | ch_we_ev;
  assign lc_we = clearing | lc_we_ev;
  assign lh_we = clearing | lh_we_ev;
  assign cf_we = clearing | cf_we_ev;
  assign g_waddr  = clearing ? clr_cnt[GB-1:0] : g_waddr_ev;
  assign s_waddr  = clearing ? clr_cnt[SB-1:0] : si;
  assign lc_waddr = clearing ? clr_cnt[LB-1:0] : lh;
  assign p_waddr  = clearing ? clr_cnt[PB-1:0] : pi;
  assign g_wd  = clearing ? CTR_WEAK_NT : g_wd_ev;
  assign s_wd  = clearing ? CTR_WEAK_NT : bump(s_rd, tk);
  assign ch_wd = clearing ? CTR_WEAK_NT : ch_wd_ev;
  assign lc_wd = clearing ? CTR_WEAK_NT : bump(lc_rd, tk);
  assign lh_wd = clearing ? '0 : (((lh << 1) | LB'(tk)) & lm);
  assign cf_wd = clearing ? 6'h3f : {cf_new[2], cf_new[1], cf_new[0]};

  mmbp_ram #(.WIDTH(2), .DEPTH(2**GB)) u_global (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wd), .raddr(g_raddr), .rdata(g_rd));
  mmbp_ram #(.WIDTH(2), .DEPTH(2**SB)) u_gshare (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wd), .raddr(si), .rdata(s_rd));
  mmbp_ram #(.WIDTH(2), .DEPTH(2**GB)) u_chooser (
    .clk(clk), .we(ch_we), .waddr(g_waddr), .wdata(ch_wd), .raddr(gh), .rdata(ch_rd));
  mmbp_ram #(.WIDTH(LB), .DEPTH(2**PB)) u_lhist (
    .clk(clk), .we(lh_we), .waddr(p_waddr), .wdata(lh_wd), .raddr(pi), .rdata(lhist_rd));
  mmbp_ram #(.WIDTH(2), .DEPTH(2**LB)) u_lctr (
    .clk(clk), .we(lc_we), .waddr(lc_waddr), .wdata(lc_wd), .raddr(lh), .rdata(lc_rd));
  mmbp_ram #(.WIDTH(6), .DEPTH(2**PB)) u_conf (
    .clk(clk), .we(cf_we), .waddr(p_waddr), .wdata(cf_wd), .raddr(pi), .rdata(cf_rd));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      mode      <= MODE_STATIC;
      gbits     <= CFG_DATA_W'(13);
      lbits     <= CFG_DATA_W'(10);
      pbits     <= CFG_DATA_W'(10);
      sbits     <= CFG_DATA_W'(13);
      ghist     <= '0;
      shist     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) clr_cnt <= clr_cnt + CW'(1);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:  mode  <= cfg_data[1:0];
          REG_GBITS: gbits <= cfg_data;
          REG_LBITS: lbits <= cfg_data;
          REG_PBITS: pbits <= cfg_data;
          REG_SBITS: sbits <= cfg_data;
          default:   mode  <= mode;
        endcase
      end
      if (hist_upd)  ghist <= ((gh << 1) | GB'(tk)) & gm;
      if (shist_upd) shist <= ((sh << 1) | SB'(tk)) & sm;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_func    <= func;
      item_pc      <= pc;
      item_outcome <= outcome;
    end
    if (out_load) prediction <= pred;
  end

endmodule

// File: sv/mmbp_checker.sv
// ----------------------------------------------------------------------------
// mmbp_checker
// port-level checks of the branch predictor, bound to the top level
// ----------------------------------------------------------------------------
module mmbp_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic prediction,
  input logic cfg_ready
);

  // clearing pass holds the input off right after reset
  a_clear_stall: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled after reset");

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(prediction)))
    else $error("stalled beat dropped or changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

endmodule

bind multi_mode_branch_predictor_unit mmbp_checker u_mmbp_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .prediction(prediction),
  .cfg_ready(cfg_ready)
);
